// ----- hdl/ctpp_pkg.sv -----
// Shared types and constants for the camera tracking packet parser.
// Used by every module of the parser; depends on nothing else.
`timescale 1ns / 1ps

package ctpp_pkg;

    localparam int PACKET_BYTES_DEF = 29;
    localparam int CHECK_POS_DEF    = 27;

    localparam logic [7:0] MSG_TYPE_RESET = 8'hD1;
    localparam logic [7:0] CHECK_SEED     = 8'h40;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [7:0] IRIS_MIN_DIRECT = 8'd7;

    localparam int POS_TYPE  = 0;
    localparam int POS_PAN   = 2;
    localparam int POS_TILT  = 5;
    localparam int POS_ROLL  = 8;
    localparam int POS_X     = 11;
    localparam int POS_Y     = 14;
    localparam int POS_Z     = 17;
    localparam int POS_ZOOM  = 20;
    localparam int POS_FOCUS = 23;
    localparam int POS_IRIS  = 26;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_LEN   = 2'd1,
        STATUS_BAD_TYPE  = 2'd2,
        STATUS_BAD_CHECK = 2'd3
    } status_t;

    // Running state after the current word has been counted in.
    typedef struct packed {
        logic [7:0] count_new;
        logic [7:0] check_new;
    } track_t;

    // Listed from the highest bits down; status sits in the lowest bits.
    typedef struct packed {
        logic [7:0]         aperture_tenths;
        logic [7:0]         iris_raw;
        logic [22:0]        focus_distance;
        logic [22:0]        focal_length;
        logic signed [23:0] pos_z;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_x;
        logic signed [23:0] roll;
        logic signed [23:0] tilt;
        logic signed [23:0] pan;
        status_t            status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- hdl/ctpp_frame_store.sv -----
// Byte counter, running checksum and datagram byte store of the parser.
// Presents the datagram with the current word merged in. Depends on ctpp_pkg.
`timescale 1ns / 1ps

module ctpp_frame_store
    import ctpp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int CHECK_POS    = CHECK_POS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic [7:0] frame [PACKET_BYTES],
    output track_t     track
);

    localparam int IDX_W = $clog2(PACKET_BYTES);

    logic [7:0] count_reg;
    logic [7:0] check_reg;
    logic [7:0] store_reg [PACKET_BYTES];
    logic [7:0] count_base;
    logic [7:0] check_base;

    assign count_base = first_byte ? 8'd0 : count_reg;
    assign check_base = first_byte ? CHECK_SEED : check_reg;

    always_comb begin
        track.count_new = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 8'd1;
        track.check_new = (count_base < 8'(CHECK_POS)) ? check_base - data_byte : check_base;
        for (int i = 0; i < PACKET_BYTES; i++) begin
            frame[i] = (count_base == 8'(i)) ? data_byte : store_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 8'd0;
            check_reg <= CHECK_SEED;
        end else if (advance) begin
            if (last_byte) begin
                count_reg <= 8'd0;
                check_reg <= CHECK_SEED;
            end else begin
                count_reg <= track.count_new;
                check_reg <= track.check_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (count_base < 8'(PACKET_BYTES))) begin
            store_reg[count_base[IDX_W-1:0]] <= data_byte;
        end
    end

endmodule

// ----- hdl/ctpp_decode.sv -----
// Checks length, type and checksum of a finished datagram and decodes its fields.
// Purely combinational; depends on ctpp_pkg.
`timescale 1ns / 1ps

module ctpp_decode
    import ctpp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int CHECK_POS    = CHECK_POS_DEF
) (
    input  logic [7:0] frame [PACKET_BYTES],
    input  track_t     track,
    input  logic [7:0] message_type,
    output result_t    result
);

    logic        check_ok;
    logic [23:0] zoom_raw;
    logic [23:0] focus_raw;
    logic [7:0]  iris;

    generate
        if (CHECK_POS < PACKET_BYTES) begin : g_check
            assign check_ok = (frame[CHECK_POS] == track.check_new);
        end else begin : g_no_check
            assign check_ok = 1'b0;
        end
    endgenerate

    assign zoom_raw  = {frame[POS_ZOOM], frame[POS_ZOOM+1], frame[POS_ZOOM+2]};
    assign focus_raw = {frame[POS_FOCUS], frame[POS_FOCUS+1], frame[POS_FOCUS+2]};
    assign iris      = frame[POS_IRIS];

    always_comb begin
        result = '0;
        if (track.count_new != 8'(PACKET_BYTES)) begin
            result.status = STATUS_BAD_LEN;
        end else if (frame[POS_TYPE] != message_type) begin
            result.status = STATUS_BAD_TYPE;
        end else if (!check_ok) begin
            result.status = STATUS_BAD_CHECK;
        end else begin
            result.status         = STATUS_OK;
            result.pan            = {frame[POS_PAN], frame[POS_PAN+1], frame[POS_PAN+2]};
            result.tilt           = {frame[POS_TILT], frame[POS_TILT+1], frame[POS_TILT+2]};
            result.roll           = {frame[POS_ROLL], frame[POS_ROLL+1], frame[POS_ROLL+2]};
            result.pos_x          = {frame[POS_X], frame[POS_X+1], frame[POS_X+2]};
            result.pos_y          = {frame[POS_Y], frame[POS_Y+1], frame[POS_Y+2]};
            result.pos_z          = {frame[POS_Z], frame[POS_Z+1], frame[POS_Z+2]};
            result.focal_length   = zoom_raw[23] ? 23'd0 : zoom_raw[22:0];
            result.focus_distance = focus_raw[23] ? 23'd0 : focus_raw[22:0];
            result.iris_raw       = iris;
            result.aperture_tenths = (iris >= IRIS_MIN_DIRECT) ? iris
                                                                : (iris << 3) + (iris << 1);
        end
    end

endmodule

// ----- hdl/camera_tracking_packet_parser.sv -----
// Camera tracking packet parser: one datagram byte per word in, one result word per datagram.
// The last byte passes the input register; its result word is then registered at the output.
// Throughput: one input word per cycle unless the input stage stalls, set by the single input
// register stage. It stalls only when a finished result still waits in the output register.
// Synchronous active-low reset clears the counter and valid flags, seeds the checksum and
// sets the message type to its reset value. Depends on ctpp_pkg, ctpp_frame_store and ctpp_decode.
`timescale 1ns / 1ps

module camera_tracking_packet_parser
    import ctpp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int CHECK_POS    = CHECK_POS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    input  logic                s_tuser,   // first_byte
    input  logic                s_tlast,   // last_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, pan, tilt, roll, pos_x, pos_y, pos_z, focal_length, focus_distance,
    // iris_raw, aperture_tenths
    output logic [RESULT_W-1:0] m_tdata
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_first_reg;
    logic          in_last_reg;
    logic [7:0]    msg_type_reg;
    logic          out_valid_reg;
    result_t       out_data_reg;
    logic          advance;
    logic [7:0]    frame [PACKET_BYTES];
    track_t        track;
    result_t       result;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_type_reg <= MSG_TYPE_RESET;
        end else if (cfg_wr_en) begin
            msg_type_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    ctpp_frame_store #(
        .PACKET_BYTES (PACKET_BYTES),
        .CHECK_POS    (CHECK_POS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .data_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .frame      (frame),
        .track      (track)
    );

    ctpp_decode #(
        .PACKET_BYTES (PACKET_BYTES),
        .CHECK_POS    (CHECK_POS)
    ) u_decode (
        .frame        (frame),
        .track        (track),
        .message_type (msg_type_reg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_data_reg <= result;
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the camera tracking packet parser: directed and random
// datagrams, with a predictor of the block and a field-by-field check of each result word.
// Depends on ctpp_pkg and camera_tracking_packet_parser.
`timescale 1ns / 1ps

module testbench;
    import ctpp_pkg::*;

    localparam int PKT_LEN      = PACKET_BYTES_DEF;
    localparam int CHK_POS      = CHECK_POS_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 400;

    typedef logic [7:0] byte_q_t[$];

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [7:0]          cfg_wr_data = 8'h00;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'h00;   // data_byte
    logic                s_tuser = 1'b0;    // first_byte
    logic                s_tlast = 1'b0;    // last_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // status, pan, tilt, roll, pos_x, pos_y, pos_z, focal_length, focus_distance,
    // iris_raw, aperture_tenths
    logic [RESULT_W-1:0] m_tdata;

    logic [7:0] trk_type;
    logic [7:0] trk_count;
    logic [7:0] trk_check;
    logic [7:0] trk_store[PKT_LEN];
    logic [7:0] cur_type;

    result_t    pose_queue[$];
    int         mismatches = 0;
    int         bytes_sent = 0;
    int         status_seen[4] = '{0, 0, 0, 0};
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    bit         stall_on = 1'b1;
    logic [31:0] stall_pat = '0;
    int         stall_left = 0;

    camera_tracking_packet_parser #(
        .PACKET_BYTES(PKT_LEN),
        .CHECK_POS   (CHK_POS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Tracks one datagram byte; returns 1 with the decoded pose when the byte ends a datagram.
    function automatic bit parse_byte(input logic [7:0] b, input logic first, input logic last,
                                      output result_t pose);
        int pos;
        logic [23:0] zoom;
        logic [23:0] focus;
        logic [7:0] iris;
        pose = '0;
        if (first) begin
            trk_count = 8'd0;
            trk_check = CHECK_SEED;
        end
        pos = trk_count;
        if (pos < PKT_LEN) trk_store[pos] = b;
        if (pos < CHK_POS) trk_check = trk_check - b;
        if (trk_count != COUNT_MAX) trk_count = trk_count + 8'd1;
        if (!last) return 1'b0;

        if (trk_count != PKT_LEN) begin
            pose.status = STATUS_BAD_LEN;
        end else if (trk_store[POS_TYPE] != trk_type) begin
            pose.status = STATUS_BAD_TYPE;
        end else if (CHK_POS >= PKT_LEN || trk_store[CHK_POS % PKT_LEN] != trk_check) begin
            pose.status = STATUS_BAD_CHECK;
        end else begin
            pose.status = STATUS_OK;
            pose.pan    = {trk_store[POS_PAN], trk_store[POS_PAN + 1], trk_store[POS_PAN + 2]};
            pose.tilt   = {trk_store[POS_TILT], trk_store[POS_TILT + 1], trk_store[POS_TILT + 2]};
            pose.roll   = {trk_store[POS_ROLL], trk_store[POS_ROLL + 1], trk_store[POS_ROLL + 2]};
            pose.pos_x  = {trk_store[POS_X], trk_store[POS_X + 1], trk_store[POS_X + 2]};
            pose.pos_y  = {trk_store[POS_Y], trk_store[POS_Y + 1], trk_store[POS_Y + 2]};
            pose.pos_z  = {trk_store[POS_Z], trk_store[POS_Z + 1], trk_store[POS_Z + 2]};
            zoom  = {trk_store[POS_ZOOM], trk_store[POS_ZOOM + 1], trk_store[POS_ZOOM + 2]};
            focus = {trk_store[POS_FOCUS], trk_store[POS_FOCUS + 1], trk_store[POS_FOCUS + 2]};
            pose.focal_length   = zoom[23] ? 23'd0 : zoom[22:0];
            pose.focus_distance = focus[23] ? 23'd0 : focus[22:0];
            iris = trk_store[POS_IRIS];
            pose.iris_raw = iris;
            if (iris >= IRIS_MIN_DIRECT) pose.aperture_tenths = iris;
            else pose.aperture_tenths = iris * 8'd10;
        end
        trk_count = 8'd0;
        trk_check = CHECK_SEED;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got) begin
            $error("Mismatch in %s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (pose_queue.size() == 0) begin
                $error("Result word with no prediction waiting: %0h", m_tdata);
                mismatches++;
            end else begin
                want = pose_queue.pop_front();
                status_seen[want.status]++;
                check_field("status", want.status, got.status);
                check_field("pan", want.pan, got.pan);
                check_field("tilt", want.tilt, got.tilt);
                check_field("roll", want.roll, got.roll);
                check_field("pos_x", want.pos_x, got.pos_x);
                check_field("pos_y", want.pos_y, got.pos_y);
                check_field("pos_z", want.pos_z, got.pos_z);
                check_field("focal_length", want.focal_length, got.focal_length);
                check_field("focus_distance", want.focus_distance, got.focus_distance);
                check_field("iris_raw", want.iris_raw, got.iris_raw);
                check_field("aperture_tenths", want.aperture_tenths, got.aperture_tenths);
            end
        end
    end

    // The receiver stalls on a shifting random pattern, now and then a long all-zero one.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_pat = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
            stall_left = 32;
        end
        m_tready <= !stall_on || stall_pat[0];
        stall_pat = stall_pat >> 1;
        stall_left--;
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        result_t pose;
        if (burst_left <= 0) begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (parse_byte(b, first, last, pose)) pose_queue.push_back(pose);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_datagram(input byte_q_t p, input bit mark_first);
        for (int i = 0; i < p.size(); i++) begin
            send_byte(p[i], mark_first && i == 0, i == p.size() - 1);
        end
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_msg_type(input logic [7:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        trk_type = value;
        cur_type = value;
    endtask

    function automatic void seal(ref byte_q_t p);
        logic [7:0] sum;
        sum = CHECK_SEED;
        for (int i = 0; i < CHK_POS; i++) sum = sum - p[i];
        p[CHK_POS] = sum;
    endfunction

    function automatic void put24(ref byte_q_t p, input int pos, input logic [23:0] v);
        p[pos]     = v[23:16];
        p[pos + 1] = v[15:8];
        p[pos + 2] = v[7:0];
    endfunction

    function automatic byte_q_t random_packet();
        byte_q_t p;
        for (int i = 0; i < PKT_LEN; i++) p.push_back(8'($urandom));
        p[POS_TYPE] = cur_type;
        if ($urandom_range(0, 2) == 0) p[POS_IRIS] = 8'($urandom_range(0, 10));
        seal(p);
        return p;
    endfunction

    task automatic test_field_extremes;
        logic [7:0]  iris_vals[8] = '{8'd0, 8'd1, 8'd3, 8'd6, 8'd7, 8'd10, 8'd128, 8'd255};
        logic [23:0] field_vals[4] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
        byte_q_t p;
        for (int k = 0; k < 8; k++) begin
            p = random_packet();
            if (k < 4) begin
                for (int f = 0; f < 8; f++) put24(p, POS_PAN + 3 * f, field_vals[k]);
            end
            p[POS_IRIS] = iris_vals[k];
            seal(p);
            send_datagram(p, 1'b1);
        end
    endtask

    task automatic test_length_errors;
        byte_q_t p;
        p = random_packet();
        void'(p.pop_back());
        send_datagram(p, 1'b1);
        p = random_packet();
        p.push_back(8'($urandom));
        send_datagram(p, 1'b1);
        send_byte(8'($urandom), 1'b1, 1'b1);
        p = random_packet();
        while (p.size() < 300) p.push_back(8'($urandom));
        send_datagram(p, 1'b1);
    endtask

    task automatic test_framing;
        // A datagram without its first mark still starts fresh after a last byte.
        send_datagram(random_packet(), 1'b0);
        // A first mark in the middle of a datagram restarts it.
        for (int i = 0; i < 7; i++) send_byte(8'($urandom), i == 0, 1'b0);
        send_datagram(random_packet(), 1'b1);
    endtask

    task automatic test_type_and_checksum;
        byte_q_t p;
        p = random_packet();
        p[POS_TYPE] = cur_type ^ 8'h01;
        seal(p);
        send_datagram(p, 1'b1);
        // The type check wins over a bad checksum, the length check over both.
        p[CHK_POS] = p[CHK_POS] + 8'd1;
        send_datagram(p, 1'b1);
        void'(p.pop_back());
        send_datagram(p, 1'b1);
        p = random_packet();
        p[CHK_POS] = p[CHK_POS] ^ 8'h80;
        send_datagram(p, 1'b1);
        p = random_packet();
        p[POS_PAN] = p[POS_PAN] + 8'd1;
        send_datagram(p, 1'b1);
        p = random_packet();
        p[PKT_LEN - 1] = ~p[PKT_LEN - 1];
        send_datagram(p, 1'b1);
    endtask

    task automatic test_msg_type_register;
        logic [7:0] settings[3] = '{8'h00, 8'hFF, 8'h5A};
        byte_q_t p;
        for (int k = 0; k < 3; k++) begin
            write_msg_type(settings[k]);
            send_datagram(random_packet(), 1'b1);
            p = random_packet();
            p[POS_TYPE] = MSG_TYPE_RESET;
            seal(p);
            send_datagram(p, 1'b1);
        end
        write_msg_type(MSG_TYPE_RESET);
    endtask

    task automatic test_random_traffic;
        int start;
        int next_switch;
        int kind;
        int len;
        byte_q_t p;
        start = bytes_sent;
        next_switch = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (bytes_sent - start >= next_switch) begin
                case ($urandom_range(0, 4))
                    0: write_msg_type(8'h00);
                    1: write_msg_type(8'hFF);
                    2: write_msg_type(MSG_TYPE_RESET);
                    default: write_msg_type(8'($urandom));
                endcase
                gaps_on  = $urandom_range(0, 2) != 0;
                stall_on = $urandom_range(0, 2) != 0;
                next_switch += 300;
            end
            kind = $urandom_range(0, 99);
            p = random_packet();
            if (kind < 70) begin
                send_datagram(p, $urandom_range(0, 9) != 0);
            end else if (kind < 78) begin
                len = $urandom_range(0, PKT_LEN - 1);
                p[len] = p[len] ^ 8'($urandom_range(1, 255));
                send_datagram(p, 1'b1);
            end else if (kind < 84) begin
                p[POS_TYPE] = cur_type ^ 8'($urandom_range(1, 255));
                seal(p);
                send_datagram(p, 1'b1);
            end else if (kind < 93) begin
                len = $urandom_range(1, 40);
                if (len == PKT_LEN) len++;
                while (p.size() > len) void'(p.pop_back());
                while (p.size() < len) p.push_back(8'($urandom));
                send_datagram(p, 1'b1);
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    initial begin
        trk_type  = MSG_TYPE_RESET;
        cur_type  = MSG_TYPE_RESET;
        trk_count = 8'd0;
        trk_check = CHECK_SEED;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_length_errors();
        test_framing();
        test_type_and_checksum();
        test_msg_type_register();
        test_random_traffic();

        wait_drained();
        $display("Sent %0d bytes under varying message types, input gaps and output stalls.",
                 bytes_sent);
        $display("Checked results: %0d ok, %0d bad length, %0d bad type, %0d bad checksum.",
                 status_seen[STATUS_OK], status_seen[STATUS_BAD_LEN],
                 status_seen[STATUS_BAD_TYPE], status_seen[STATUS_BAD_CHECK]);
        if (mismatches == 0 && pose_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ctpp_pkg.sv
hdl/ctpp_frame_store.sv
hdl/ctpp_decode.sv
hdl/camera_tracking_packet_parser.sv
sim/testbench.sv
